/* hdl/hrdr_pkg.sv */
// shared types, constants and calendar helpers for the holiday rule date resolver
package hrdr_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_WEEKEND_MASK = 2'd0,
    CFG_WINDOW_START = 2'd1,
    CFG_WINDOW_END   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // rule kinds
  typedef enum logic [1:0] {
    KIND_FIXED   = 2'd0,
    KIND_NTH     = 2'd1,
    KIND_LAST    = 2'd2,
    KIND_EASTER  = 2'd3
  } kind_e;

  // observance shifts
  typedef enum logic [1:0] {
    SHIFT_NONE    = 2'd0,
    SHIFT_NEAREST = 2'd1,
    SHIFT_MONDAY  = 2'd2,
    SHIFT_RSVD    = 2'd3
  } shift_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_HOLIDAY  = 3'd0,
    ST_INACTIVE = 3'd1,
    ST_NO_DATE  = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_WEEKEND  = 3'd4
  } status_e;

  localparam int unsigned YearW   = 14;
  localparam int unsigned DayNumW = 24;
  localparam int unsigned WinW    = 23;

  localparam logic [6:0]       WeekendReset = 7'd65;
  localparam logic [WinW-1:0]  WinStartReset = 23'd0;
  localparam logic [WinW-1:0]  WinEndReset   = 23'd2932896;

  // weekday codes
  localparam logic [2:0] Sunday   = 3'd0;
  localparam logic [2:0] Saturday = 3'd6;

  // reciprocals for exact division of bounded values by constants
  localparam int unsigned S100Y = 21;
  localparam int unsigned M100Y = (2**S100Y + 99) / 100;
  localparam int unsigned S100P = 22;
  localparam int unsigned M100P = (2**S100P + 99) / 100;
  localparam int unsigned S19   = 19;
  localparam int unsigned M19   = (2**S19 + 18) / 19;
  localparam int unsigned S25   = 13;
  localparam int unsigned M25   = (2**S25 + 24) / 25;
  localparam int unsigned S3    = 10;
  localparam int unsigned M3    = (2**S3 + 2) / 3;
  localparam int unsigned S30   = 15;
  localparam int unsigned M30   = (2**S30 + 29) / 30;
  localparam int unsigned S7S   = 13;
  localparam int unsigned M7S   = (2**S7S + 6) / 7;
  localparam int unsigned S7W   = 18;
  localparam int unsigned M7W   = (2**S7W + 6) / 7;

  // day number of January 1 of year zero offset, days since 1970-01-01
  localparam int unsigned Jan1Bias = 719624;

  // one input word
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [1:0]       kind;
    logic [3:0]       month;
    logic [4:0]       dom;
    logic [2:0]       weekday;
    logic [2:0]       occ;
    logic [7:0]       offset;
    logic [1:0]       shift;
    logic [4:0]       present;
    logic             active;
  } item_t;

  // value below 1024 modulo 7
  function automatic logic [2:0] mod7_small(input logic [9:0] x);
    logic [20:0] p;
    logic [9:0]  q;
    p = 21'(x) * 21'(M7S);
    q = 10'(p[20:S7S]);
    return 3'(x - 10'(q * 10'd7));
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // length of a month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2:                     r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

/* hdl/holiday_rule_date_resolver.sv */
// holiday rule date resolver: nine stage pipeline from rule word to observed date
//
// One rule word enters on any cycle start_i is high; busy_o is always low, so a
// word can be issued every clock. Each word gives exactly one result word, shown
// for one cycle with done_o high, in issue order. The Easter chain (year split,
// century terms, epact, weekday correction) and the day-of-year to month lookup
// each take their own stages. Configuration writes take effect at once and should
// be made while no word is in flight.
module holiday_rule_date_resolver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [hrdr_pkg::YearW-1:0]     year_i,
  input  logic [1:0]                     rule_kind_i,
  input  logic [3:0]                     month_i,
  input  logic [4:0]                     day_of_month_i,
  input  logic [2:0]                     weekday_i,
  input  logic [2:0]                     occurrence_i,
  input  logic signed [7:0]              day_offset_i,
  input  logic [1:0]                     observance_shift_i,
  input  logic [4:0]                     present_mask_i,
  input  logic                           rule_active_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [hrdr_pkg::WinW-1:0]      cfg_wdata_i,
  output logic                           done_o,
  output logic [hrdr_pkg::YearW-1:0]     observed_year_o,
  output logic [3:0]                     observed_month_o,
  output logic [4:0]                     observed_day_o,
  output logic [2:0]                     observed_weekday_o,
  output logic [2:0]                     status_o
);

  // configuration registers
  logic [6:0]                  weekend_q;
  logic [hrdr_pkg::WinW-1:0]   win_start_q, win_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weekend_q   <= hrdr_pkg::WeekendReset;
      win_start_q <= hrdr_pkg::WinStartReset;
      win_end_q   <= hrdr_pkg::WinEndReset;
    end else if (cfg_we_i) begin
      unique case (hrdr_pkg::cfg_idx_e'(cfg_index_i))
        hrdr_pkg::CFG_WEEKEND_MASK: weekend_q   <= cfg_wdata_i[6:0];
        hrdr_pkg::CFG_WINDOW_START: win_start_q <= cfg_wdata_i;
        hrdr_pkg::CFG_WINDOW_END:   win_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid bits per stage
  logic [9:1] v_q, v_d;
  assign v_d = {v_q[8:1], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  hrdr_pkg::item_t it_d;
  hrdr_pkg::item_t it_q [1:7];

  assign it_d = '{year: year_i, kind: rule_kind_i, month: month_i, dom: day_of_month_i,
                  weekday: weekday_i, occ: occurrence_i, offset: day_offset_i,
                  shift: observance_shift_i, present: present_mask_i,
                  active: rule_active_i};

  // ---------------- stage 1: century and golden number splits
  logic [14:0] p_s0;
  logic [29:0] pb_s0;
  logic [28:0] pa_s0;
  logic [30:0] pp_s0;
  logic [9:0]  q19_s0;
  logic [7:0]  b1_d, pq1_d;
  logic [6:0]  c1_d;
  logic [4:0]  a1_d;
  logic [12:0] p4_1_d;
  logic [7:0]  b1_q, pq1_q;
  logic [6:0]  c1_q;
  logic [4:0]  a1_q;
  logic [12:0] p4_1_q;

  always_comb begin
    p_s0   = 15'(year_i) + 15'd399;
    pb_s0  = 30'(year_i) * 30'(hrdr_pkg::M100Y);
    b1_d   = pb_s0[hrdr_pkg::S100Y +: 8];
    c1_d   = 7'(year_i - 14'(14'(b1_d) * 14'd100));
    pa_s0  = 29'(year_i) * 29'(hrdr_pkg::M19);
    q19_s0 = pa_s0[hrdr_pkg::S19 +: 10];
    a1_d   = 5'(year_i - 14'(14'(q19_s0) * 14'd19));
    pp_s0  = 31'(p_s0) * 31'(hrdr_pkg::M100P);
    pq1_d  = pp_s0[hrdr_pkg::S100P +: 8];
    p4_1_d = p_s0[14:2];
  end

  always_ff @(posedge clk_i) begin
    it_q[1] <= it_d;
    b1_q    <= b1_d;
    c1_q    <= c1_d;
    a1_q    <= a1_d;
    pq1_q   <= pq1_d;
    p4_1_q  <= p4_1_d;
  end

  // ---------------- stage 2: leap counts, leap flags, Easter f term
  logic [12:0] l2_d, l2_q;
  logic        lp2_d, lpp2_d, lp2_q, lpp2_q;
  logic [20:0] pf_s1;
  logic [2:0]  f2_d, f2_q;
  logic [8:0]  a19_2_d, a19_2_q;
  logic [7:0]  b2_q;
  logic [6:0]  c2_q;
  logic [4:0]  a2_q;

  always_comb begin
    l2_d    = p4_1_q - 13'(pq1_q) + 13'(pq1_q[7:2]);
    lp2_d   = (it_q[1].year[1:0] == 2'd0) && ((c1_q != 7'd0) || (b1_q[1:0] == 2'd0));
    lpp2_d  = (it_q[1].year[1:0] == 2'd1) && ((c1_q != 7'd1) || (b1_q[1:0] == 2'd0));
    pf_s1   = 21'(9'(b1_q) + 9'd8) * 21'(hrdr_pkg::M25);
    f2_d    = pf_s1[hrdr_pkg::S25 +: 3];
    a19_2_d = 9'(a1_q) * 9'd19;
  end

  always_ff @(posedge clk_i) begin
    it_q[2] <= it_q[1];
    l2_q    <= l2_d;
    lp2_q   <= lp2_d;
    lpp2_q  <= lpp2_d;
    f2_q    <= f2_d;
    a19_2_q <= a19_2_d;
    b2_q    <= b1_q;
    c2_q    <= c1_q;
    a2_q    <= a1_q;
  end

  // ---------------- stage 3: January 1 day number and weekday, Easter g term, month data
  logic [14:0] yl_s2;
  logic [31:0] pw_s2;
  logic [11:0] qw_s2;
  logic [2:0]  rw_s2;
  logic [8:0]  gx_s2;
  logic [17:0] pg_s2;
  logic [2:0]  jw3_d, jw3_q;
  logic signed [hrdr_pkg::DayNumW-1:0] dn3_d, dn3_q;
  logic [5:0]  g3_d, g3_q;
  logic [8:0]  cm3_d, cm3_q;
  logic [4:0]  ml3_d, ml3_q;
  logic        mv3_d, mv3_q;
  logic [8:0]  a19_3_q;
  logic [7:0]  b3_q;
  logic [6:0]  c3_q;
  logic [4:0]  a3_q;
  logic        lp3_q, lpp3_q;

  always_comb begin
    yl_s2 = 15'(it_q[2].year) + 15'(l2_q);
    pw_s2 = 32'(yl_s2) * 32'(hrdr_pkg::M7W);
    qw_s2 = pw_s2[hrdr_pkg::S7W +: 12];
    rw_s2 = 3'(yl_s2 - 15'(15'(qw_s2) * 15'd7));
    jw3_d = (rw_s2 == 3'd6) ? 3'd0 : rw_s2 + 3'd1;
    dn3_d = $signed(24'(24'(it_q[2].year) * 24'd365)) + $signed(24'(l2_q))
            - $signed(24'(hrdr_pkg::Jan1Bias));
    gx_s2 = 9'(b2_q) - 9'(f2_q) + 9'd1;
    pg_s2 = 18'(gx_s2) * 18'(hrdr_pkg::M3);
    g3_d  = pg_s2[hrdr_pkg::S3 +: 6];
    mv3_d = (it_q[2].month >= 4'd1) && (it_q[2].month <= 4'd12);
    cm3_d = hrdr_pkg::cum_days(it_q[2].month)
            + 9'((it_q[2].month > 4'd2) && lp2_q);
    ml3_d = hrdr_pkg::month_len(it_q[2].month, lp2_q);
  end

  always_ff @(posedge clk_i) begin
    it_q[3] <= it_q[2];
    jw3_q   <= jw3_d;
    dn3_q   <= dn3_d;
    g3_q    <= g3_d;
    cm3_q   <= cm3_d;
    ml3_q   <= ml3_d;
    mv3_q   <= mv3_d;
    a19_3_q <= a19_2_q;
    b3_q    <= b2_q;
    c3_q    <= c2_q;
    a3_q    <= a2_q;
    lp3_q   <= lp2_q;
    lpp3_q  <= lpp2_q;
  end

  // ---------------- stage 4: Easter epact, month weekday rules and fixed dates
  logic [9:0]  hx_s3;
  logic [20:0] ph_s3;
  logic [4:0]  qh_s3;
  logic [4:0]  h4_d, h4_q;
  logic [2:0]  wf_s3, wl_s3, dif_s3, bk_s3;
  logic [5:0]  fd_s3;
  logic        mw_s3, occ_ok_s3;
  logic [9:0]  doyc4_d, doyc4_q;
  logic        okc4_d, okc4_q;
  logic [4:0]  a4_q;
  logic [6:0]  c4_q;
  logic [1:0]  e4_q;
  logic [2:0]  jw4_q;
  logic signed [hrdr_pkg::DayNumW-1:0] dn4_q;
  logic        lp4_q, lpp4_q;

  always_comb begin
    hx_s3  = 10'(a19_3_q) + 10'(b3_q) - 10'(b3_q[7:2]) - 10'(g3_q) + 10'd15;
    ph_s3  = 21'(hx_s3) * 21'(hrdr_pkg::M30);
    qh_s3  = ph_s3[hrdr_pkg::S30 +: 5];
    h4_d   = 5'(hx_s3 - 10'(10'(qh_s3) * 10'd30));
    wf_s3  = hrdr_pkg::mod7_small(10'(jw3_q) + 10'(cm3_q));
    wl_s3  = hrdr_pkg::mod7_small(10'(jw3_q) + 10'(cm3_q) + 10'(ml3_q) - 10'd1);
    dif_s3 = (it_q[3].weekday >= wf_s3) ? it_q[3].weekday - wf_s3
                                        : it_q[3].weekday + 3'd7 - wf_s3;
    bk_s3  = (wl_s3 >= it_q[3].weekday) ? wl_s3 - it_q[3].weekday
                                        : wl_s3 + 3'd7 - it_q[3].weekday;
    fd_s3  = 6'(dif_s3) + 6'(6'(it_q[3].occ) * 6'd7) - 6'd6;
    occ_ok_s3 = (it_q[3].occ >= 3'd1) && (it_q[3].occ <= 3'd5);
    mw_s3  = it_q[3].present[0] && it_q[3].present[2] && mv3_q
             && (it_q[3].weekday <= 3'd6);
    unique case (hrdr_pkg::kind_e'(it_q[3].kind))
      hrdr_pkg::KIND_FIXED: begin
        doyc4_d = 10'(cm3_q) + 10'(it_q[3].dom) - 10'd1;
        okc4_d  = it_q[3].present[0] && it_q[3].present[1] && mv3_q
                  && (it_q[3].dom != 5'd0);
      end
      hrdr_pkg::KIND_NTH: begin
        doyc4_d = 10'(cm3_q) + 10'(fd_s3) - 10'd1;
        okc4_d  = mw_s3 && it_q[3].present[3] && occ_ok_s3 && (fd_s3 <= 6'(ml3_q));
      end
      hrdr_pkg::KIND_LAST: begin
        doyc4_d = 10'(cm3_q) + 10'(ml3_q) - 10'd1 - 10'(bk_s3);
        okc4_d  = mw_s3;
      end
      default: begin
        doyc4_d = 10'd0;
        okc4_d  = it_q[3].present[4];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q[4] <= it_q[3];
    h4_q    <= h4_d;
    doyc4_q <= doyc4_d;
    okc4_q  <= okc4_d;
    a4_q    <= a3_q;
    c4_q    <= c3_q;
    e4_q    <= b3_q[1:0];
    jw4_q   <= jw3_q;
    dn4_q   <= dn3_q;
    lp4_q   <= lp3_q;
    lpp4_q  <= lpp3_q;
  end

  // ---------------- stage 5: Easter weekday correction
  logic [7:0] lx_s4;
  logic [2:0] l5_d, l5_q;
  logic [8:0] h11_5_d, h11_5_q;
  logic [4:0] h5_q, a5_q;
  logic [9:0] doyc5_q;
  logic       okc5_q;
  logic [2:0] jw5_q;
  logic signed [hrdr_pkg::DayNumW-1:0] dn5_q;
  logic       lp5_q, lpp5_q;

  always_comb begin
    lx_s4   = 8'd32 + {5'd0, e4_q, 1'b0} + {2'd0, c4_q[6:2], 1'b0}
              - 8'(h4_q) - 8'(c4_q[1:0]);
    l5_d    = hrdr_pkg::mod7_small(10'(lx_s4));
    h11_5_d = 9'(h4_q) * 9'd11;
  end

  always_ff @(posedge clk_i) begin
    it_q[5] <= it_q[4];
    l5_q    <= l5_d;
    h11_5_q <= h11_5_d;
    h5_q    <= h4_q;
    a5_q    <= a4_q;
    doyc5_q <= doyc4_q;
    okc5_q  <= okc4_q;
    jw5_q   <= jw4_q;
    dn5_q   <= dn4_q;
    lp5_q   <= lp4_q;
    lpp5_q  <= lpp4_q;
  end

  // ---------------- stage 6: Easter day of year plus offset, natural date select
  logic [9:0] mx_s5;
  logic [7:0] t_s5;
  logic [6:0] de_s5;
  logic signed [10:0] doy6_d, doy6_q;
  logic [2:0] jw6_q;
  logic signed [hrdr_pkg::DayNumW-1:0] dn6_q;
  logic       ok6_q, lp6_q, lpp6_q;

  always_comb begin
    mx_s5 = 10'(a5_q) + 10'(h11_5_q) + 10'(10'(l5_q) * 10'd22);
    t_s5  = 8'(h5_q) + 8'(l5_q) + 8'd114 - ((mx_s5 >= 10'd451) ? 8'd7 : 8'd0);
    de_s5 = 7'(t_s5 - 8'd34) + 7'(lp5_q);
    if (hrdr_pkg::kind_e'(it_q[5].kind) == hrdr_pkg::KIND_EASTER) begin
      doy6_d = $signed({4'd0, de_s5}) + $signed({{3{it_q[5].offset[7]}}, it_q[5].offset});
    end else begin
      doy6_d = $signed({1'b0, doyc5_q});
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[6] <= it_q[5];
    doy6_q  <= doy6_d;
    ok6_q   <= okc5_q;
    jw6_q   <= jw5_q;
    dn6_q   <= dn5_q;
    lp6_q   <= lp5_q;
    lpp6_q  <= lpp5_q;
  end

  // ---------------- stage 7: natural weekday and observance shift
  logic [10:0] doyb_s6;
  logic [2:0]  w0_s6;
  logic [2:0]  w7_d, w7_q;
  logic signed [10:0] dl_s6;
  logic signed [10:0] doy7_d, doy7_q;
  logic signed [hrdr_pkg::DayNumW-1:0] dn7_q;
  logic        ok7_q, lp7_q, lpp7_q;

  always_comb begin
    doyb_s6 = 11'(doy6_q + 11'sd49);
    w0_s6   = hrdr_pkg::mod7_small(10'(jw6_q) + doyb_s6[9:0]);
    dl_s6   = 11'sd0;
    w7_d    = w0_s6;
    unique case (hrdr_pkg::shift_e'(it_q[6].shift))
      hrdr_pkg::SHIFT_NEAREST: begin
        if (w0_s6 == hrdr_pkg::Saturday) begin
          dl_s6 = -11'sd1;
          w7_d  = 3'd5;
        end else if (w0_s6 == hrdr_pkg::Sunday) begin
          dl_s6 = 11'sd1;
          w7_d  = 3'd1;
        end
      end
      hrdr_pkg::SHIFT_MONDAY: begin
        if (w0_s6 == hrdr_pkg::Saturday) begin
          dl_s6 = 11'sd2;
          w7_d  = 3'd1;
        end else if (w0_s6 == hrdr_pkg::Sunday) begin
          dl_s6 = 11'sd1;
          w7_d  = 3'd1;
        end
      end
      default: ;
    endcase
    doy7_d = doy6_q + dl_s6;
  end

  always_ff @(posedge clk_i) begin
    it_q[7] <= it_q[6];
    w7_q    <= w7_d;
    doy7_q  <= doy7_d;
    dn7_q   <= dn6_q;
    ok7_q   <= ok6_q;
    lp7_q   <= lp6_q;
    lpp7_q  <= lpp6_q;
  end

  // ---------------- stage 8: year rollover, window and weekend checks
  logic signed [hrdr_pkg::DayNumW-1:0] n_s7, ws_s7, we_s7;
  logic signed [10:0] ylen_s7, plen_s7;
  logic [hrdr_pkg::YearW-1:0] y8_d, y8_q;
  logic [8:0]  dy8_d, dy8_q;
  logic        ly8_d, ly8_q;
  logic [2:0]  st8_d, st8_q;
  logic [2:0]  w8_q;

  always_comb begin
    n_s7    = dn7_q + 24'(doy7_q);
    ws_s7   = 24'(signed'(win_start_q));
    we_s7   = 24'(signed'(win_end_q));
    ylen_s7 = 11'sd365 + $signed({10'd0, lp7_q});
    plen_s7 = 11'sd365 + $signed({10'd0, lpp7_q});
    if (doy7_q < 11'sd0) begin
      y8_d  = it_q[7].year - 14'd1;
      dy8_d = 9'(doy7_q + plen_s7);
      ly8_d = lpp7_q;
    end else if (doy7_q >= ylen_s7) begin
      y8_d  = it_q[7].year + 14'd1;
      dy8_d = 9'(doy7_q - ylen_s7);
      ly8_d = 1'b0;
    end else begin
      y8_d  = it_q[7].year;
      dy8_d = 9'(doy7_q);
      ly8_d = lp7_q;
    end
    priority if (!it_q[7].active) begin
      st8_d = hrdr_pkg::ST_INACTIVE;
    end else if (!ok7_q) begin
      st8_d = hrdr_pkg::ST_NO_DATE;
    end else if ((n_s7 < ws_s7) || (n_s7 > we_s7)) begin
      st8_d = hrdr_pkg::ST_OUTSIDE;
    end else if (weekend_q[w7_q]) begin
      st8_d = hrdr_pkg::ST_WEEKEND;
    end else begin
      st8_d = hrdr_pkg::ST_HOLIDAY;
    end
  end

  always_ff @(posedge clk_i) begin
    y8_q    <= y8_d;
    dy8_q   <= dy8_d;
    ly8_q   <= ly8_d;
    st8_q   <= st8_d;
    w8_q    <= w7_q;
  end

  // ---------------- stage 9: month and day from day of year, output word
  logic [3:0] mo_s8;
  logic [8:0] base_s8;
  logic [8:0] start_s8;
  logic       blank_s8;
  logic [hrdr_pkg::YearW-1:0] oy_q;
  logic [3:0] om_q;
  logic [4:0] od_q;
  logic [2:0] ow_q, os_q;

  always_comb begin
    mo_s8   = 4'd1;
    base_s8 = 9'd0;
    for (int m = 2; m <= 12; m++) begin
      start_s8 = hrdr_pkg::cum_days(4'(m)) + 9'((m > 2) && ly8_q);
      if (dy8_q >= start_s8) begin
        mo_s8   = 4'(m);
        base_s8 = start_s8;
      end
    end
    blank_s8 = (st8_q == hrdr_pkg::ST_INACTIVE) || (st8_q == hrdr_pkg::ST_NO_DATE);
  end

  always_ff @(posedge clk_i) begin
    oy_q <= blank_s8 ? '0 : y8_q;
    om_q <= blank_s8 ? 4'd0 : mo_s8;
    od_q <= blank_s8 ? 5'd0 : 5'(dy8_q - base_s8 + 9'd1);
    ow_q <= blank_s8 ? 3'd0 : w8_q;
    os_q <= st8_q;
  end

  assign done_o             = v_q[9];
  assign observed_year_o    = oy_q;
  assign observed_month_o   = om_q;
  assign observed_day_o     = od_q;
  assign observed_weekday_o = ow_q;
  assign status_o           = os_q;

endmodule

/* sim/testbench.sv */
// self-checking testbench for the holiday rule date resolver
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StallLimit  = 5000;

  // one rule word as driven on the input ports
  typedef struct {
    logic [13:0] year;
    logic [1:0]  kind;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [2:0]  wday;
    logic [2:0]  occ;
    logic [7:0]  offset;
    logic [1:0]  shift;
    logic [4:0]  present;
    logic        active;
  } rule_t;

  // one observed date word
  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [2:0]  status;
  } observed_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [13:0] year_i;
  logic [1:0]  rule_kind_i;
  logic [3:0]  month_i;
  logic [4:0]  day_of_month_i;
  logic [2:0]  weekday_i;
  logic [2:0]  occurrence_i;
  logic signed [7:0] day_offset_i;
  logic [1:0]  observance_shift_i;
  logic [4:0]  present_mask_i;
  logic        rule_active_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [22:0] cfg_wdata_i;
  logic        done_o;
  logic [13:0] observed_year_o;
  logic [3:0]  observed_month_o;
  logic [4:0]  observed_day_o;
  logic [2:0]  observed_weekday_o;
  logic [2:0]  status_o;

  holiday_rule_date_resolver dut (.*);

  // predictor copy of the registers
  logic [6:0]  weekend_bits = hrdr_pkg::WeekendReset;
  longint      win_first    = 0;
  longint      win_last     = 2932896;

  rule_t       rules_to_send[$];
  observed_t   dates_due[$];
  int          send_idle_pct = 0;
  int          rules_queued = 0;
  int          rules_taken = 0;
  int          dates_seen = 0;
  int          errors = 0;
  int          quiet_cycles = 0;
  int          status_count[5] = '{default: 0};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // calendar arithmetic on days since 1970-01-01
  function automatic longint days_of(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = y - (m <= 2 ? 1 : 0) + 400;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468 - 146097;
  endfunction

  function automatic longint dow_of(longint n);
    return ((n % 7) + 7 + 4) % 7;
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // easter sunday by the anonymous gregorian algorithm
  function automatic longint easter_days(longint y);
    longint a, b, c, d, e, f, g, h, i, k, l, m, t;
    a = y % 19; b = y / 100; c = y % 100;
    d = b / 4;  e = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b - d - g + 15) % 30;
    i = c / 4;  k = c % 4;
    l = (32 + 2 * e + 2 * i - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    t = h + l - 7 * m + 114;
    return days_of(y, t / 31, (t % 31) + 1);
  endfunction

  // expected observed date word for one rule
  function automatic observed_t resolve_rule(rule_t r);
    observed_t o;
    longint y, mo, n, w, first, fd, last, z, era, doe, yoe, doy, mp, dd, mm, yr;
    bit ok, has_m, has_d, has_w, has_o, has_off, mw;
    o = '{default: '0};
    y = r.year; mo = r.month;
    has_m = r.present[0]; has_d = r.present[1]; has_w = r.present[2];
    has_o = r.present[3]; has_off = r.present[4];
    ok = 0; n = 0;
    if (!r.active) begin
      o.status = hrdr_pkg::ST_INACTIVE;
      return o;
    end
    mw = has_m && has_w && mo >= 1 && mo <= 12 && r.wday <= 6;
    case (hrdr_pkg::kind_e'(r.kind))
      hrdr_pkg::KIND_FIXED: begin
        if (has_m && has_d && mo >= 1 && mo <= 12 && r.dom >= 1) begin
          n = days_of(y, mo, r.dom);
          ok = 1;
        end
      end
      hrdr_pkg::KIND_NTH: begin
        if (mw && has_o && r.occ >= 1 && r.occ <= 5) begin
          first = days_of(y, mo, 1);
          fd = 1 + (longint'(r.wday) - dow_of(first) + 7) % 7 + 7 * (longint'(r.occ) - 1);
          if (fd <= days_in_month(y, mo)) begin
            n = first + fd - 1;
            ok = 1;
          end
        end
      end
      hrdr_pkg::KIND_LAST: begin
        if (mw) begin
          last = days_of(y, mo, days_in_month(y, mo));
          n = last - (dow_of(last) - longint'(r.wday) + 7) % 7;
          ok = 1;
        end
      end
      default: begin
        if (has_off) begin
          n = easter_days(y) + longint'($signed(r.offset));
          ok = 1;
        end
      end
    endcase
    if (!ok) begin
      o.status = hrdr_pkg::ST_NO_DATE;
      return o;
    end
    // observance shift, reserved code behaves as none
    w = dow_of(n);
    if (r.shift == hrdr_pkg::SHIFT_NEAREST) begin
      if (w == 6) n -= 1;
      else if (w == 0) n += 1;
    end else if (r.shift == hrdr_pkg::SHIFT_MONDAY) begin
      if (w == 6) n += 2;
      else if (w == 0) n += 1;
    end
    w = dow_of(n);
    // back to a civil date
    z   = n + 719468 + 146097;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dd  = doy - (153 * mp + 2) / 5 + 1;
    mm  = mp < 10 ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 - 400 + (mm <= 2 ? 1 : 0);
    o.year  = yr[13:0];
    o.month = mm[3:0];
    o.day   = dd[4:0];
    o.wday  = w[2:0];
    if (n < win_first || n > win_last) o.status = hrdr_pkg::ST_OUTSIDE;
    else if (weekend_bits[w]) o.status = hrdr_pkg::ST_WEEKEND;
    else o.status = hrdr_pkg::ST_HOLIDAY;
    return o;
  endfunction

  function automatic rule_t make_rule(int y, hrdr_pkg::kind_e k, int m, int d, int wd,
                                      int oc, int off, hrdr_pkg::shift_e sh, int pm,
                                      bit act);
    rule_t r;
    r.year = y[13:0]; r.kind = k; r.month = m[3:0]; r.dom = d[4:0];
    r.wday = wd[2:0]; r.occ = oc[2:0]; r.offset = off[7:0]; r.shift = sh;
    r.present = pm[4:0]; r.active = act;
    return r;
  endfunction

  // random rule, mostly well formed with random content
  function automatic rule_t random_rule();
    rule_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) r.year = 14'($urandom_range(9999, 1583));
    else if (pick < 85) r.year = 14'($urandom_range(2045, 1975));
    else r.year = 14'($urandom);
    r.kind    = 2'($urandom);
    r.month   = ($urandom_range(99) < 88) ? 4'($urandom_range(12, 1)) : 4'($urandom);
    r.dom     = 5'($urandom);
    r.wday    = ($urandom_range(99) < 90) ? 3'($urandom_range(6)) : 3'($urandom);
    r.occ     = ($urandom_range(99) < 85) ? 3'($urandom_range(5, 1)) : 3'($urandom);
    r.offset  = 8'($urandom);
    r.shift   = 2'($urandom);
    r.present = ($urandom_range(99) < 80) ? 5'h1f : 5'($urandom);
    r.active  = ($urandom_range(99) < 92);
    return r;
  endfunction

  // driver: one word per accepting edge, gaps at the configured rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        dates_due.insert(dates_due.size(), resolve_rule('{year_i, rule_kind_i, month_i,
            day_of_month_i, weekday_i, occurrence_i, day_offset_i, observance_shift_i,
            present_mask_i, rule_active_i}));
        rules_taken++;
      end
      if ((!start_i || !busy_o) && rules_to_send.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        rule_t r;
        r = rules_to_send.pop_front();
        start_i            <= 1'b1;
        year_i             <= r.year;
        rule_kind_i        <= r.kind;
        month_i            <= r.month;
        day_of_month_i     <= r.dom;
        weekday_i          <= r.wday;
        occurrence_i       <= r.occ;
        day_offset_i       <= r.offset;
        observance_shift_i <= r.shift;
        present_mask_i     <= r.present;
        rule_active_i      <= r.active;
      end else if (!start_i || !busy_o) begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      observed_t e;
      if (dates_due.size() == 0) begin
        $display("%0t: result word with nothing expected, status %0d", $time, status_o);
        errors++;
      end else begin
        e = dates_due.pop_front();
        check_field("observed_year", e.year, observed_year_o);
        check_field("observed_month", e.month, observed_month_o);
        check_field("observed_day", e.day, observed_day_o);
        check_field("observed_weekday", e.wday, observed_weekday_o);
        check_field("status", e.status, status_o);
        if (e.status <= hrdr_pkg::ST_WEEKEND) status_count[e.status]++;
      end
      dates_seen++;
    end
  end

  // watchdog on cycles without any accepted word or result word
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: timeout, no word accepted in %0d cycles", $time, StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(hrdr_pkg::cfg_idx_e idx, longint value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[22:0];
    case (idx)
      hrdr_pkg::CFG_WEEKEND_MASK: weekend_bits = value[6:0];
      hrdr_pkg::CFG_WINDOW_START: win_first = longint'($signed(value[22:0]));
      hrdr_pkg::CFG_WINDOW_END:   win_last = longint'($signed(value[22:0]));
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued word is in and every result is back
  task automatic drain();
    wait (rules_taken == rules_queued && dates_due.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    repeat (count) begin
      rules_to_send.insert(rules_to_send.size(), random_rule());
      rules_queued++;
    end
  endtask

  task automatic queue_rule(rule_t r);
    rules_to_send.insert(rules_to_send.size(), r);
    rules_queued++;
  endtask

  // stimulus
  initial begin
    start_i = 1'b0; year_i = '0; rule_kind_i = '0; month_i = '0; day_of_month_i = '0;
    weekday_i = '0; occurrence_i = '0; day_offset_i = '0; observance_shift_i = '0;
    present_mask_i = '0; rule_active_i = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = hrdr_pkg::CFG_WEEKEND_MASK; cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under reset settings
    queue_rule(make_rule(2000, hrdr_pkg::KIND_FIXED, 1, 1, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 2, 31, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 12, 31, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 5, 0, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 0, 5, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 13, 5, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 15, 5, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 30, 1));
    queue_rule(make_rule(2020, hrdr_pkg::KIND_FIXED, 7, 4, 0, 1, 0,
                         hrdr_pkg::SHIFT_NEAREST, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 7, 4, 0, 1, 0,
                         hrdr_pkg::SHIFT_NEAREST, 31, 1));
    queue_rule(make_rule(2020, hrdr_pkg::KIND_FIXED, 7, 4, 0, 1, 0,
                         hrdr_pkg::SHIFT_MONDAY, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 7, 4, 0, 1, 0,
                         hrdr_pkg::SHIFT_RSVD, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_NTH, 11, 1, 4, 4, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_NTH, 2, 1, 1, 5, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_NTH, 3, 1, 1, 0, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_NTH, 3, 1, 1, 7, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_NTH, 3, 1, 7, 2, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_LAST, 5, 1, 1, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_LAST, 5, 1, 1, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 29, 1));
    queue_rule(make_rule(2024, hrdr_pkg::KIND_EASTER, 0, 0, 0, 0, -128,
                         hrdr_pkg::SHIFT_NONE, 16, 1));
    queue_rule(make_rule(2024, hrdr_pkg::KIND_EASTER, 0, 0, 0, 0, 127,
                         hrdr_pkg::SHIFT_MONDAY, 16, 1));
    queue_rule(make_rule(1583, hrdr_pkg::KIND_EASTER, 0, 0, 0, 0, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 1));
    queue_rule(make_rule(9999, hrdr_pkg::KIND_EASTER, 0, 0, 0, 0, 1,
                         hrdr_pkg::SHIFT_NONE, 15, 1));
    queue_rule(make_rule(0, hrdr_pkg::KIND_FIXED, 1, 1, 0, 1, 0,
                         hrdr_pkg::SHIFT_NEAREST, 31, 1));
    queue_rule(make_rule(16383, hrdr_pkg::KIND_LAST, 12, 31, 6, 7, -1,
                         hrdr_pkg::SHIFT_MONDAY, 31, 1));
    queue_rule(make_rule(2021, hrdr_pkg::KIND_FIXED, 1, 1, 0, 1, 0,
                         hrdr_pkg::SHIFT_NONE, 31, 0));
    drain();

    // wide window extremes, no weekend days, sender idles often
    write_reg(hrdr_pkg::CFG_WEEKEND_MASK, 0);
    write_reg(hrdr_pkg::CFG_WINDOW_START, -200000);
    write_reg(hrdr_pkg::CFG_WINDOW_END, 3000000);
    send_idle_pct = 23;
    queue_random(130);
    drain();

    // narrow window, every day a weekend day, sender idles most cycles
    write_reg(hrdr_pkg::CFG_WEEKEND_MASK, 127);
    write_reg(hrdr_pkg::CFG_WINDOW_START, days_of(1990, 1, 1));
    write_reg(hrdr_pkg::CFG_WINDOW_END, days_of(2030, 12, 31));
    send_idle_pct = 61;
    queue_random(130);
    drain();

    // random mask, window from the epoch, back to back words
    write_reg(hrdr_pkg::CFG_WEEKEND_MASK, $urandom_range(127));
    write_reg(hrdr_pkg::CFG_WINDOW_START, 0);
    write_reg(hrdr_pkg::CFG_WINDOW_END, days_of(2040, 6, 30));
    send_idle_pct = 0;
    queue_random(140);
    drain();

    $display("%0d rule words checked over four register settings and three idle rates",
             dates_seen);
    $display("status mix: holiday %0d, inactive %0d, no date %0d, outside %0d, weekend %0d",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4]);
    if (errors == 0 && dates_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
